// ===== design/lst_pkg.sv =====
// Package for the latency statistics tracker.
// Holds the shared constants, payload structs and divider request and response types.
// No dependencies.
package lst_pkg;

  localparam int SAMPLE_DEPTH = 1024;
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] sample_ns;
    logic [16:0] percentile_fraction;
  } item_t;

  typedef struct packed {
    logic [47:0] sample_total;
    logic [63:0] latency_sum;
    logic [31:0] latency_min;
    logic [31:0] latency_max;
    logic [31:0] average_latency;
    logic [31:0] percentile_value;
    logic        is_empty;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/lst_front.sv =====
// Front end: accepts items and holds them in a two-entry queue.
// Depends on lst_pkg.
module lst_front import lst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  cmd_valid,
  output item_t cmd,
  input  logic  cmd_take
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign item_stall = (count == 2'd2);
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = q[rd_ptr];
  assign push       = item_valid && !item_stall;
  assign pop        = cmd_take && cmd_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/lst_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the mean.
// Depends on lst_pkg.
module lst_divider import lst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [47:0] rem;
  logic [63:0] quo;
  logic [6:0]  steps;
  logic        busy;
  logic        done;
  logic [48:0] shifted;
  logic [48:0] diff;

  assign shifted = {rem, quo[63]};
  assign diff    = shifted - {1'b0, req.divisor};

  // Control: step counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= 7'd64;
      end else if (busy) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift, trial subtract, restore.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= 48'd0;
      quo <= req.dividend;
    end else if (busy) begin
      if (!diff[48]) begin
        rem <= diff[47:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[47:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo[31:0];

endmodule

// ===== design/lst_back.sv =====
// Back end: running statistics, sample ring memory, rank search and result register.
// Depends on lst_pkg and lst_divider.
module lst_back import lst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  item_t   cmd,
  output logic    cmd_take,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] mem [SAMPLE_DEPTH];
  logic [31:0] rdata;
  logic [AW-1:0] ptr;
  logic [47:0] count;
  logic [63:0] sum;
  logic [31:0] vmin;
  logic [31:0] vmax;
  logic [31:0] mean;
  logic [31:0] pval;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] mid;
  logic [CW-1:0] n;
  logic [CW-1:0] nq;
  logic [CW-1:0] rank;
  logic [CW-1:0] addr;
  logic [CW-1:0] acc;
  logic [CW-1:0] acc_final;
  logic        issuing;
  logic        rvalid;
  logic        rlast;
  logic        hit;
  logic        wen;
  logic [64:0] sum_wide;
  logic [16+CW:0] prod;
  logic [CW:0]   rank_raw;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign wen      = cmd_take && (cmd.action == ACT_RECORD);
  assign sum_wide = {1'b0, sum} + {33'd0, cmd.sample_ns};
  assign nq       = (count < 48'(SAMPLE_DEPTH)) ? count[CW-1:0] : CW'(SAMPLE_DEPTH);
  assign prod     = {{CW{1'b0}}, cmd.percentile_fraction} * {17'd0, nq};
  assign rank_raw = prod[16+CW:16];
  assign mid      = lo + ((hi - lo) >> 1);
  assign hit      = rvalid && (rdata <= mid);
  assign acc_final = acc + CW'(hit);

  // Sample ring memory.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[ptr] <= cmd.sample_ns;
    end
    rdata <= mem[addr[AW-1:0]];
  end

  // Divider for the mean.
  assign dreq.start    = (state == S_START);
  assign dreq.dividend = sum;
  assign dreq.divisor  = count;

  lst_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Running statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      count <= 48'd0;
      sum   <= 64'd0;
      vmin  <= 32'hFFFF_FFFF;
      vmax  <= 32'd0;
    end else if (wen) begin
      if (count != COUNT_MAX) begin
        count <= count + 48'd1;
      end
      sum <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
      if (cmd.sample_ns < vmin) begin
        vmin <= cmd.sample_ns;
      end
      if (cmd.sample_ns > vmax) begin
        vmax <= cmd.sample_ns;
      end
      ptr <= (ptr == AW'(SAMPLE_DEPTH - 1)) ? '0 : ptr + AW'(1);
    end
  end

  // Sequencer: rank search passes over the memory, then the mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      rvalid  <= 1'b0;
      rlast   <= 1'b0;
      addr    <= '0;
      acc     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            pval <= 32'd0;
            mean <= 32'd0;
            if (cmd.action == ACT_RECORD) begin
              state <= S_START;
            end else if (nq == '0) begin
              state <= S_DONE;
            end else begin
              n       <= nq;
              rank    <= (rank_raw >= {1'b0, nq}) ? nq - CW'(1) : rank_raw[CW-1:0];
              lo      <= 32'd0;
              hi      <= 32'hFFFF_FFFF;
              addr    <= '0;
              acc     <= '0;
              issuing <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rvalid <= issuing;
          rlast  <= issuing && (addr == n - CW'(1));
          if (issuing) begin
            addr <= addr + CW'(1);
            if (addr == n - CW'(1)) begin
              issuing <= 1'b0;
            end
          end
          if (rlast) begin
            // End of one pass: narrow the search interval.
            acc  <= '0;
            addr <= '0;
            if (acc_final > rank) begin
              hi <= mid;
              if (lo < mid) begin
                issuing <= 1'b1;
              end else begin
                pval  <= lo;
                state <= S_START;
              end
            end else begin
              lo <= mid + 32'd1;
              if ((mid + 32'd1) < hi) begin
                issuing <= 1'b1;
              end else begin
                pval  <= mid + 32'd1;
                state <= S_START;
              end
            end
          end else begin
            acc <= acc_final;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            mean  <= drsp.quotient;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result_valid || !result_stall)) begin
      result.sample_total     <= count;
      result.latency_sum      <= sum;
      result.latency_min      <= vmin;
      result.latency_max      <= vmax;
      result.average_latency  <= mean;
      result.percentile_value <= pval;
      result.is_empty         <= (count == 48'd0);
    end
  end

`ifndef SYNTHESIS
  // A new result only comes from the delivery state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside delivery state");

  // The search interval never inverts while scanning.
  a_interval: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (lo <= hi))
    else $error("search interval inverted");

  // The ring pointer stays inside the memory.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wen |=> ({1'b0, ptr} < (AW + 1)'(SAMPLE_DEPTH)))
    else $error("write pointer out of range");

  // No item is taken while a search or division is in progress.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_DIV)) |-> !cmd_take)
    else $error("item taken while busy");
`endif

endmodule

// ===== design/latency_statistics_tracker.sv =====
// Latency statistics tracker, top level.
// Record item: updates the statistics, then runs the mean divider to the result.
// Query item: up to 32 search passes over the sample memory,
// each reading all stored samples, plus the divider. A new item is taken
// only after the last result is registered; a two-entry queue absorbs bursts.
// Synchronous active-high reset clears the statistics; the memory is not cleared.
module latency_statistics_tracker import lst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic  cmd_valid;
  logic  cmd_take;
  item_t cmd;

  // Input queue.
  lst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // Execution and result delivery.
  lst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the latency statistics tracker.
// It predicts count, sum, min, max, mean and percentile for every transfer and checks each result.
// Depends on lst_pkg and latency_statistics_tracker.
`timescale 1ns / 100ps

module testbench;
  import lst_pkg::*;

  localparam int LIMIT_CYCLES = 6_000_000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Predictor state for the tracker.
  logic [31:0] stored_samples [SAMPLE_DEPTH];
  int unsigned wr_index = 0;
  logic [47:0] total_recorded = '0;
  logic [63:0] total_latency = '0;
  logic [31:0] lowest_latency = '1;
  logic [31:0] highest_latency = '0;

  result_t expected_stats[$];
  int      error_count = 0;
  longint  cycle_count = 0;
  bit      idle_on = 1'b1;

  latency_statistics_tracker dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #2 clk = ~clk;

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** latency_statistics_tracker: FAILED **");
      $finish;
    end
  end

  // Compute the statistics that one accepted item produces.
  function automatic result_t predict_stats(item_t it);
    result_t     r;
    logic [64:0] wide_sum;
    int unsigned n;
    longint unsigned rank;
    logic [31:0] sorted[];
    r = '0;
    if (it.action == ACT_RECORD) begin
      if (total_recorded < COUNT_MAX) total_recorded = total_recorded + 1;
      wide_sum = {1'b0, total_latency} + {33'd0, it.sample_ns};
      total_latency = wide_sum[64] ? '1 : wide_sum[63:0];
      if (it.sample_ns < lowest_latency) lowest_latency = it.sample_ns;
      if (it.sample_ns > highest_latency) highest_latency = it.sample_ns;
      stored_samples[wr_index] = it.sample_ns;
      wr_index = (wr_index + 1) % SAMPLE_DEPTH;
    end else begin
      n = (total_recorded < SAMPLE_DEPTH) ? int'(total_recorded) : SAMPLE_DEPTH;
      if (n > 0) begin
        rank = (longint'(it.percentile_fraction) * n) >> 16;
        if (rank >= n) rank = n - 1;
        sorted = new[n];
        for (int i = 0; i < n; i++) sorted[i] = stored_samples[i];
        sorted.sort();
        r.percentile_value = sorted[rank];
      end
    end
    r.sample_total = total_recorded;
    r.latency_sum = total_latency;
    r.latency_min = lowest_latency;
    r.latency_max = highest_latency;
    if (total_recorded != 0) r.average_latency = 32'(total_latency / total_recorded);
    r.is_empty = (total_recorded == 0);
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      error_count++;
      $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycle_count);
    end
  endtask

  // Send one item; called right after a rising edge, returns after the transfer.
  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(99) < 20) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    expected_stats.push_back(predict_stats(it));
  endtask

  task automatic send_record(logic [31:0] sample);
    item_t it;
    it.action = ACT_RECORD;
    it.sample_ns = sample;
    it.percentile_fraction = 17'($urandom);
    send_item(it);
  endtask

  task automatic send_query(logic [16:0] frac);
    item_t it;
    it.action = ACT_QUERY;
    it.sample_ns = $urandom;
    it.percentile_fraction = frac;
    send_item(it);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall and in-order checking.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_stats.size() == 0) begin
        error_count++;
        $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        want = expected_stats.pop_front();
        report("sample_total", result.sample_total, want.sample_total);
        report("latency_sum", result.latency_sum, want.latency_sum);
        report("latency_min", result.latency_min, want.latency_min);
        report("latency_max", result.latency_max, want.latency_max);
        report("average_latency", result.average_latency, want.average_latency);
        report("percentile_value", result.percentile_value, want.percentile_value);
        report("is_empty", result.is_empty, want.is_empty);
      end
    end
    result_stall <= idle_on && ($urandom_range(99) < 20);
  end

  // Queries before any sample return zero mean and percentile.
  task automatic test_empty_query();
    send_query(17'd0);
    send_query(17'd65536);
    send_query(17'h1FFFF);
  endtask

  // Extreme samples, duplicates and the rank clamp.
  task automatic test_directed();
    send_record(32'd0);
    send_query(17'd65536);
    send_record(32'hFFFF_FFFF);
    send_query(17'd32768);
    send_record(32'd7);
    send_record(32'd7);
    send_record(32'h8000_0000);
    send_query(17'd0);
    send_query(17'd32768);
    send_query(17'd65535);
    send_query(17'd65536);
    send_query(17'h1FFFF);
    send_record(32'h5555_5555);
    send_record(32'hAAAA_AAAA);
    send_query(17'h0AAAA);
    send_query(17'h15555);
  endtask

  // Mostly records with rare queries; one stretch without idling and one drain pause.
  task automatic test_random_traffic();
    logic [31:0] s;
    for (int i = 0; i < 830; i++) begin
      idle_on = (i >= 150);
      if (i == 500) wait_drained();
      if ($urandom_range(99) < 2) begin
        send_query(17'($urandom));
      end else begin
        case ($urandom_range(3))
          0: s = $urandom_range(20);
          1: s = 32'hFFFF_FFF0 | 32'($urandom_range(15));
          default: s = $urandom;
        endcase
        send_record(s);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_query();
    test_directed();
    test_random_traffic();
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("** latency_statistics_tracker: PASSED **");
    end else begin
      $display("** latency_statistics_tracker: FAILED **");
    end
    $finish;
  end

endmodule
